@@ hdl/ssdh_pkg.sv @@
// ----------------------------------------------------------------------------
// ssdh_pkg
// Shared types and constants for the sweep scanner with detect-and-hold.
// ----------------------------------------------------------------------------
package ssdh_pkg;

    localparam logic [14:0] ECHO_TIMEOUT_US = 15'd30000;

    localparam logic [7:0]  ANGLE_RESET     = 8'd90;
    localparam logic [7:0]  SERVO_MAX_DEG   = 8'd180;
    localparam logic [10:0] SERVO_BASE_US   = 11'd1000;

    // floor(x / 29) == (x * 18079) >> 19 for x < 2^14, used for echo / 58
    localparam logic [14:0] DIV29_RECIP     = 15'd18079;
    // floor(a * 1000 / 180) == (a * 364100) >> 16 for a <= 180
    localparam logic [18:0] PULSE_RECIP     = 19'd364100;
    // floor(a / 3) == (a * 171) >> 9 for a < 512
    localparam logic [8:0]  DIV3_RECIP      = 9'd171;

    localparam logic [3:0]  COUNT_MAX       = 4'd15;

    typedef enum logic [2:0] {
        CFG_DETECT_DIST  = 3'd0,
        CFG_RELEASE_DIST = 3'd1,
        CFG_DETECT_CNT   = 3'd2,
        CFG_RELEASE_CNT  = 3'd3,
        CFG_SWEEP_MIN    = 3'd4,
        CFG_SWEEP_MAX    = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic       timeout;
        logic [9:0] dist_cm;   // already 0 on timeout
    } t_meas;

    typedef struct packed {
        logic       object_held;
        logic       distance_valid;
        logic [9:0] distance_cm;
        logic       measured;
        logic [10:0] servo_pulse_us;
        logic [7:0] angle_deg;
    } t_result;

endpackage

@@ hdl/ssdh_in_stage.sv @@
// ----------------------------------------------------------------------------
// ssdh_in_stage
// Input register; converts the echo width to a distance and timeout flag.
// ----------------------------------------------------------------------------
module ssdh_in_stage
    import ssdh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_take,
    input  logic [14:0] i_echo_us,
    output logic        o_valid,
    output t_meas       o_meas
);

    logic        r_valid;
    t_meas       r_meas;
    t_meas       n_meas;
    logic [28:0] w_prod;
    logic        w_timeout;

    // echo / 58 == (echo >> 1) / 29
    assign w_prod    = 29'(i_echo_us[14:1]) * 29'(DIV29_RECIP);
    assign w_timeout = (i_echo_us == 15'd0) || (i_echo_us >= ECHO_TIMEOUT_US);

    always_comb begin
        n_meas.timeout = w_timeout;
        n_meas.dist_cm = w_timeout ? 10'd0 : w_prod[28:19];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_meas <= n_meas;
        end
    end

    assign o_valid = r_valid;
    assign o_meas  = r_meas;

endmodule

@@ hdl/ssdh_core.sv @@
// ----------------------------------------------------------------------------
// ssdh_core
// Configuration registers, sweep state and the per-step decision logic.
// ----------------------------------------------------------------------------
module ssdh_core
    import ssdh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_step,
    input  t_meas       i_meas,
    output t_result     o_result
);

    logic [9:0] r_detect_dist;
    logic [9:0] r_release_dist;
    logic [3:0] r_detect_cnt;
    logic [3:0] r_release_cnt;
    logic [7:0] r_sweep_min;
    logic [7:0] r_sweep_max;

    logic [7:0] r_angle;
    logic       r_rising;
    logic       r_hold;
    logic [3:0] r_near;
    logic [3:0] r_far;

    logic [7:0] n_angle;
    logic       n_rising;
    logic       n_hold;
    logic [3:0] n_near;
    logic [3:0] n_far;

    logic [16:0] w_div3;
    logic [8:0]  w_times3;
    logic        w_on_grid;
    logic [7:0]  w_servo_deg;
    logic [26:0] w_pulse_prod;
    logic        w_advance;
    logic [3:0]  w_near_inc;
    logic [3:0]  w_far_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_dist  <= 10'd25;
            r_release_dist <= 10'd30;
            r_detect_cnt   <= 4'd2;
            r_release_cnt  <= 4'd3;
            r_sweep_min    <= 8'd10;
            r_sweep_max    <= 8'd170;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_DETECT_DIST:  r_detect_dist  <= i_cfg_data;
                CFG_RELEASE_DIST: r_release_dist <= i_cfg_data;
                CFG_DETECT_CNT:   r_detect_cnt   <= i_cfg_data[3:0];
                CFG_RELEASE_CNT:  r_release_cnt  <= i_cfg_data[3:0];
                CFG_SWEEP_MIN:    r_sweep_min    <= i_cfg_data[7:0];
                CFG_SWEEP_MAX:    r_sweep_max    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // measurement grid: angle is a multiple of 3
    assign w_div3    = 17'(r_angle) * 17'(DIV3_RECIP);
    assign w_times3  = 9'({w_div3[15:9], 1'b0}) + 9'(w_div3[15:9]);
    assign w_on_grid = (9'(r_angle) == w_times3);

    assign w_servo_deg  = (r_angle > SERVO_MAX_DEG) ? SERVO_MAX_DEG : r_angle;
    assign w_pulse_prod = 27'(w_servo_deg) * 27'(PULSE_RECIP);

    assign w_near_inc = (r_near < COUNT_MAX) ? r_near + 4'd1 : COUNT_MAX;
    assign w_far_inc  = (r_far  < COUNT_MAX) ? r_far  + 4'd1 : COUNT_MAX;

    always_comb begin
        n_hold    = r_hold;
        n_near    = r_near;
        n_far     = r_far;
        w_advance = 1'b0;

        if (!r_hold) begin
            if (!w_on_grid) begin
                w_advance = 1'b1;
            end else begin
                if (!i_meas.timeout && (i_meas.dist_cm <= r_detect_dist)) begin
                    n_near = w_near_inc;
                    if (w_near_inc >= r_detect_cnt) begin
                        n_hold = 1'b1;
                        n_near = 4'd0;
                        n_far  = 4'd0;
                    end
                end else begin
                    n_near = 4'd0;
                end
                // angle stays put while a detection is pending or just confirmed
                w_advance = !n_hold && (n_near == 4'd0);
            end
        end else begin
            n_far = (i_meas.timeout || (i_meas.dist_cm >= r_release_dist)) ? w_far_inc : 4'd0;
            if (n_far >= r_release_cnt) begin
                n_hold = 1'b0;
                n_far  = 4'd0;
                n_near = 4'd0;
            end
        end

        n_angle  = r_angle;
        n_rising = r_rising;
        if (w_advance) begin
            if (r_rising) begin
                if (r_angle >= r_sweep_max) begin
                    n_rising = 1'b0;
                    n_angle  = r_angle - 8'd1;
                end else begin
                    n_angle  = r_angle + 8'd1;
                end
            end else begin
                if (r_angle <= r_sweep_min) begin
                    n_rising = 1'b1;
                    n_angle  = r_angle + 8'd1;
                end else begin
                    n_angle  = r_angle - 8'd1;
                end
            end
        end
    end

    always_comb begin
        o_result.angle_deg      = r_angle;
        o_result.servo_pulse_us = SERVO_BASE_US + w_pulse_prod[26:16];
        o_result.measured       = r_hold || w_on_grid;
        o_result.distance_cm    = (r_hold || w_on_grid) ? i_meas.dist_cm : 10'd0;
        o_result.distance_valid = (r_hold || w_on_grid) && !i_meas.timeout;
        o_result.object_held    = n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle  <= ANGLE_RESET;
            r_rising <= 1'b1;
            r_hold   <= 1'b0;
            r_near   <= 4'd0;
            r_far    <= 4'd0;
        end else if (i_step) begin
            r_angle  <= n_angle;
            r_rising <= n_rising;
            r_hold   <= n_hold;
            r_near   <= n_near;
            r_far    <= n_far;
        end
    end

endmodule

@@ hdl/sweep_scanner_detect_hold_top.sv @@
// ----------------------------------------------------------------------------
// sweep_scanner_detect_hold_top
// Servo sweep scanner that freezes on a confirmed near object.
// ----------------------------------------------------------------------------
// Each input transfer is one servo step carrying an echo width in us (0 or
// at/above 30000 is a timeout); each step yields exactly one output transfer
// with the commanded angle, servo pulse, distance and mode. The block takes
// one transfer per clock unless the output stalls, through an input register,
// where the echo is turned into a distance, and a result register. The sweep
// state is updated in the same cycle a step moves from the input register to
// the result register, so consecutive steps never wait on each other; only
// back-pressure on the output side slows the input. Configuration writes are
// taken at any time and apply to steps that reach the result stage afterward.
// ----------------------------------------------------------------------------
module sweep_scanner_detect_hold_top
    import ssdh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [14:0] echo_us, [15] zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [7:0] angle_deg, [18:8] servo_pulse_us,
                                        // [19] measured, [29:20] distance_cm,
                                        // [30] distance_valid, [31] object_held
);

    logic    w_in_valid;
    t_meas   w_meas;
    t_result w_result;
    logic    w_load;
    logic    w_step;

    logic    r_out_valid;
    t_result r_out;
    logic    n_out_valid;

    assign w_step        = w_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !w_in_valid || w_step;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    ssdh_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_take    (w_step),
        .i_echo_us (s_axis_tdata[14:0]),
        .o_valid   (w_in_valid),
        .o_meas    (w_meas)
    );

    ssdh_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (w_step),
        .i_meas      (w_meas),
        .o_result    (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.object_held, r_out.distance_valid, r_out.distance_cm,
                            r_out.measured, r_out.servo_pulse_us, r_out.angle_deg};

    // a held step always measures
    a_held_measures: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.object_held |-> r_out.measured)
        else $error("held step without measurement");

    // no distance reported unless the step measured
    a_dist_needs_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.measured |-> !r_out.distance_valid && (r_out.distance_cm == 10'd0))
        else $error("distance on a non-measuring step");

    // a stalled result register does not pull a new step through
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !w_step)
        else $error("result overwritten while stalled");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.servo_pulse_us >= 11'd1000) && (r_out.servo_pulse_us <= 11'd2000))
        else $error("servo pulse out of range");

endmodule
